// ===== hdl/gsg_pkg.sv =====
`timescale 1ns / 1ps

package gsg_pkg;

	localparam int YAW_W      = 48;
	localparam int PITCH_W    = 21;
	localparam int RATE_W     = 17;
	localparam int STICK_W    = 11;
	localparam int SWITCH_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [SWITCH_W-1:0]       SWITCH_ACTIVE  = 2'd2;
	localparam logic                      PATROL_ENABLE  = 1'b1;
	localparam logic signed [STICK_W-1:0] WHEEL_DEADBAND = 11'sd50;

	// Division by 660 is a division of n/4 by 165 done with a rounded-up reciprocal.
	// Pitch: n/4 = mag*64 < 2^29, recip = ceil(2^37/165), so q = (mag*recip) >> 31.
	// Wheel: n/4 < 2^24, recip = ceil(2^32/165), so q = ((n>>2)*recip) >> 32.
	localparam logic [29:0] PITCH_RECIP = 30'd832963355;
	localparam logic [24:0] WHEEL_RECIP = 25'd26030105;
	localparam logic [15:0] RATE_MAX    = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YAW_STICK_GAIN,
		REG_PITCH_STICK_GAIN,
		REG_PITCH_CENTER,
		REG_PITCH_UPPER,
		REG_PITCH_LOWER,
		REG_YAW_PATROL_STEP,
		REG_PITCH_PATROL_STEP,
		REG_SHOOT_FULL_RATE
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] yaw_stick_gain;
		logic [12:0] pitch_stick_gain;
		logic [12:0] pitch_center;
		logic [12:0] pitch_upper;
		logic [12:0] pitch_lower;
		logic [19:0] yaw_patrol_step;
		logic [15:0] pitch_patrol_step;
		logic [15:0] shoot_full_rate;
	} cfg_t;

	typedef struct packed {
		logic [SWITCH_W-1:0]       mode_switch;
		logic [SWITCH_W-1:0]       friction_switch;
		logic signed [STICK_W-1:0] stick_yaw;
		logic signed [STICK_W-1:0] stick_pitch;
		logic signed [STICK_W-1:0] wheel;
		logic                      fire_request;
	} tick_t;

	typedef struct packed {
		logic host;
		logic fric;
		logic fire;
		logic pitch_set;
		logic wheel_pos;
		logic wheel_neg;
	} ctl_t;

	typedef struct packed {
		ctl_t               ctl;
		logic signed [27:0] yaw_prod;
		logic               pitch_neg;
		logic [23:0]        pitch_mag;
		logic               wheel_neg;
		logic [26:0]        wheel_mag;
	} prod_t;

	typedef struct packed {
		ctl_t                     ctl;
		logic signed [27:0]       yaw_prod;
		logic signed [23:0]       pitch_off;
		logic signed [RATE_W-1:0] wheel_rate;
	} scaled_t;

endpackage

// ===== hdl/gsg_tick_if.sv =====
`timescale 1ns / 1ps

interface gsg_tick_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode_switch;
	logic [1:0]        friction_switch;
	logic signed [10:0] stick_yaw;
	logic signed [10:0] stick_pitch;
	logic signed [10:0] wheel;
	logic              fire_request;

	modport source (output valid, mode_switch, friction_switch, stick_yaw, stick_pitch,
		wheel, fire_request, input ready);
	modport sink (input valid, mode_switch, friction_switch, stick_yaw, stick_pitch,
		wheel, fire_request, output ready);
endinterface

// ===== hdl/gsg_setpt_if.sv =====
`timescale 1ns / 1ps

interface gsg_setpt_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] yaw_setpoint;
	logic [20:0]        pitch_setpoint;
	logic               friction_on;
	logic signed [16:0] feeder_one_rate;
	logic signed [16:0] feeder_two_rate;

	modport source (output valid, yaw_setpoint, pitch_setpoint, friction_on,
		feeder_one_rate, feeder_two_rate, input ready);
	modport sink (input valid, yaw_setpoint, pitch_setpoint, friction_on,
		feeder_one_rate, feeder_two_rate, output ready);
endinterface

// ===== hdl/gsg_cfg_regs.sv =====
`timescale 1ns / 1ps

module gsg_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsg_pkg::CFG_DATA_W-1:0] cfg_data,
	output gsg_pkg::cfg_t                  cfg
);
	import gsg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.yaw_stick_gain    <= 16'd26;
			cfg_q.pitch_stick_gain  <= 13'd568;
			cfg_q.pitch_center      <= 13'd6000;
			cfg_q.pitch_upper       <= 13'd7500;
			cfg_q.pitch_lower       <= 13'd4100;
			cfg_q.yaw_patrol_step   <= 20'd5243;
			cfg_q.pitch_patrol_step <= 16'd640;
			cfg_q.shoot_full_rate   <= 16'd5000;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_YAW_STICK_GAIN:    cfg_q.yaw_stick_gain    <= cfg_data[15:0];
				REG_PITCH_STICK_GAIN:  cfg_q.pitch_stick_gain  <= cfg_data[12:0];
				REG_PITCH_CENTER:      cfg_q.pitch_center      <= cfg_data[12:0];
				REG_PITCH_UPPER:       cfg_q.pitch_upper       <= cfg_data[12:0];
				REG_PITCH_LOWER:       cfg_q.pitch_lower       <= cfg_data[12:0];
				REG_YAW_PATROL_STEP:   cfg_q.yaw_patrol_step   <= cfg_data[19:0];
				REG_PITCH_PATROL_STEP: cfg_q.pitch_patrol_step <= cfg_data[15:0];
				REG_SHOOT_FULL_RATE:   cfg_q.shoot_full_rate   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hdl/gsg_scale.sv =====
`timescale 1ns / 1ps

// Two stages: stick and wheel products, then the truncating divide by full stick.
module gsg_scale (
	input  logic             clk,
	input  logic             ld_s2,
	input  logic             ld_s3,
	input  gsg_pkg::cfg_t    cfg,
	input  gsg_pkg::tick_t   tick_s1,
	output gsg_pkg::scaled_t scaled_s3
);
	import gsg_pkg::*;

	prod_t       prod_d;
	prod_t       prod_s2;
	scaled_t     scaled_d;
	scaled_t     scaled_q3;
	logic [10:0] pitch_abs;
	logic [10:0] wheel_abs;
	logic [53:0] pitch_full;
	logic [22:0] pitch_quo;
	logic [49:0] wheel_full;
	logic [17:0] wheel_quo;
	logic [15:0] wheel_sat;

	always_comb begin
		pitch_abs = tick_s1.stick_pitch[10] ? 11'(~tick_s1.stick_pitch + 11'd1)
			: tick_s1.stick_pitch;
		wheel_abs = tick_s1.wheel[10] ? 11'(~tick_s1.wheel + 11'd1) : tick_s1.wheel;

		prod_d.ctl.host      = (tick_s1.mode_switch == SWITCH_ACTIVE);
		prod_d.ctl.fric      = (tick_s1.friction_switch == SWITCH_ACTIVE);
		prod_d.ctl.fire      = tick_s1.fire_request;
		prod_d.ctl.pitch_set = (tick_s1.stick_pitch != '0);
		prod_d.ctl.wheel_pos = (tick_s1.wheel >= WHEEL_DEADBAND);
		prod_d.ctl.wheel_neg = (tick_s1.wheel <= -WHEEL_DEADBAND);
		prod_d.yaw_prod      = tick_s1.stick_yaw * $signed({1'b0, cfg.yaw_stick_gain});
		prod_d.pitch_neg     = tick_s1.stick_pitch[10];
		prod_d.pitch_mag     = pitch_abs * cfg.pitch_stick_gain;
		prod_d.wheel_neg     = tick_s1.wheel[10];
		prod_d.wheel_mag     = wheel_abs * cfg.shoot_full_rate;
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			prod_s2 <= prod_d;
		end
	end

	always_comb begin
		pitch_full = prod_s2.pitch_mag * PITCH_RECIP;
		pitch_quo  = pitch_full[53:31];
		wheel_full = prod_s2.wheel_mag[26:2] * WHEEL_RECIP;
		wheel_quo  = wheel_full[49:32];
		wheel_sat  = (wheel_quo > {2'b00, RATE_MAX}) ? RATE_MAX : wheel_quo[15:0];

		scaled_d.ctl        = prod_s2.ctl;
		scaled_d.yaw_prod   = prod_s2.yaw_prod;
		scaled_d.pitch_off  = prod_s2.pitch_neg ? $signed(24'(~{1'b0, pitch_quo} + 24'd1))
			: $signed({1'b0, pitch_quo});
		scaled_d.wheel_rate = prod_s2.wheel_neg ? $signed(17'(~{1'b0, wheel_sat} + 17'd1))
			: $signed({1'b0, wheel_sat});
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			scaled_q3 <= scaled_d;
		end
	end

	assign scaled_s3 = scaled_q3;
endmodule

// ===== hdl/gsg_update.sv =====
`timescale 1ns / 1ps

// Angle state and the result word; the state only moves when a result is loaded.
module gsg_update (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ld_out,
	input  gsg_pkg::cfg_t                        cfg,
	input  gsg_pkg::scaled_t                     scaled_s3,
	output logic signed [gsg_pkg::YAW_W-1:0]     yaw_setpoint,
	output logic [gsg_pkg::PITCH_W-1:0]          pitch_setpoint,
	output logic                                 friction_on,
	output logic signed [gsg_pkg::RATE_W-1:0]    feeder_one_rate,
	output logic signed [gsg_pkg::RATE_W-1:0]    feeder_two_rate
);
	import gsg_pkg::*;

	logic [YAW_W-1:0]          yaw_q, yaw_d;
	logic [PITCH_W-1:0]        pitch_q, pitch_d;
	logic                      sweep_down_q, sweep_down_d;
	logic                      friction_q;
	logic signed [RATE_W-1:0]  feed_one_q, feed_one_d;
	logic signed [RATE_W-1:0]  feed_two_q, feed_two_d;
	logic signed [24:0]        upper_s, lower_s, p_raw, p_hi, p_lo;
	logic [PITCH_W-1:0]        upper_u, lower_u;
	logic signed [22:0]        sweep_sum;
	logic [PITCH_W-1:0]        sweep_pitch;
	logic signed [RATE_W-1:0]  full_rate;

	always_comb begin
		upper_u   = {cfg.pitch_upper, 8'b0};
		lower_u   = {cfg.pitch_lower, 8'b0};
		upper_s   = $signed({4'b0, upper_u});
		lower_s   = $signed({4'b0, lower_u});
		full_rate = $signed({1'b0, cfg.shoot_full_rate});

		// Manual pitch: clamp to the upper limit first so that crossed limits give lower.
		p_raw = $signed({4'b0, cfg.pitch_center, 8'b0}) + 25'(scaled_s3.pitch_off);
		p_hi  = (p_raw > upper_s) ? upper_s : p_raw;
		p_lo  = (p_hi < lower_s) ? lower_s : p_hi;

		sweep_sum = sweep_down_q
			? $signed({2'b0, pitch_q}) - $signed({7'b0, cfg.pitch_patrol_step})
			: $signed({2'b0, pitch_q}) + $signed({7'b0, cfg.pitch_patrol_step});
		if (sweep_sum[22]) begin
			sweep_pitch = '0;
		end else if (sweep_sum[21]) begin
			sweep_pitch = '1;
		end else begin
			sweep_pitch = sweep_sum[20:0];
		end

		yaw_d        = yaw_q;
		pitch_d      = pitch_q;
		sweep_down_d = sweep_down_q;
		feed_one_d   = '0;
		feed_two_d   = '0;

		if (!scaled_s3.ctl.host) begin
			yaw_d = yaw_q - YAW_W'(scaled_s3.yaw_prod);
			if (scaled_s3.ctl.pitch_set) begin
				pitch_d = p_lo[20:0];
			end
			if (scaled_s3.ctl.wheel_pos) begin
				feed_one_d = -scaled_s3.wheel_rate;
			end else if (scaled_s3.ctl.wheel_neg) begin
				feed_two_d = -scaled_s3.wheel_rate;
			end
		end else begin
			if (PATROL_ENABLE && !scaled_s3.ctl.fire) begin
				yaw_d   = yaw_q + YAW_W'(cfg.yaw_patrol_step);
				pitch_d = sweep_pitch;
				if (sweep_pitch > upper_u) begin
					sweep_down_d = 1'b1;
				end
				if (sweep_pitch < lower_u) begin
					sweep_down_d = 1'b0;
				end
			end
			if (scaled_s3.ctl.fric && scaled_s3.ctl.fire) begin
				feed_one_d = -full_rate;
				feed_two_d = full_rate;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q        <= '0;
			pitch_q      <= '0;
			sweep_down_q <= 1'b0;
		end else if (ld_out) begin
			yaw_q        <= yaw_d;
			pitch_q      <= pitch_d;
			sweep_down_q <= sweep_down_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			friction_q <= scaled_s3.ctl.fric;
			feed_one_q <= feed_one_d;
			feed_two_q <= feed_two_d;
		end
	end

	assign yaw_setpoint    = $signed(yaw_q);
	assign pitch_setpoint  = pitch_q;
	assign friction_on     = friction_q;
	assign feeder_one_rate = feed_one_q;
	assign feeder_two_rate = feed_two_q;
endmodule

// ===== hdl/gimbal_setpoint_generator.sv =====
`timescale 1ns / 1ps

// Gimbal setpoint generator. One word on tick gives one word on setpt, in order. A word
// can be accepted every cycle while tick.ready is high; it passes through the input register,
// multiply stage, divide-by-full-stick stage and result register in that order, and the
// angle state is updated at the same edge that loads the result register. The pipeline
// keeps moving while a finished result waits: tick.ready drops only when every stage
// holds a word and setpt.ready is low. Registers are written through cfg_we, cfg_index
// and cfg_data, and must only be written when no word is in flight.
module gimbal_setpoint_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gsg_pkg::CFG_DATA_W-1:0] cfg_data,
	gsg_tick_if.sink                       tick,
	gsg_setpt_if.source                    setpt
);
	import gsg_pkg::*;

	cfg_t    cfg;
	tick_t   tick_s1;
	scaled_t scaled_s3;
	logic    valid_s1, valid_s2, valid_s3, out_valid_q;
	logic    adv_out, rdy_s3, rdy_s2, rdy_s1;
	logic    ld_s2, ld_s3, ld_out;

	assign adv_out = !out_valid_q || setpt.ready;
	assign rdy_s3  = !valid_s3 || adv_out;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign ld_s2   = valid_s1 && rdy_s2;
	assign ld_s3   = valid_s2 && rdy_s3;
	assign ld_out  = valid_s3 && adv_out;

	assign tick.ready  = rdy_s1;
	assign setpt.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= tick.valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && rdy_s1) begin
			tick_s1.mode_switch     <= tick.mode_switch;
			tick_s1.friction_switch <= tick.friction_switch;
			tick_s1.stick_yaw       <= tick.stick_yaw;
			tick_s1.stick_pitch     <= tick.stick_pitch;
			tick_s1.wheel           <= tick.wheel;
			tick_s1.fire_request    <= tick.fire_request;
		end
	end

	gsg_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gsg_scale u_scale (
		.clk       (clk),
		.ld_s2     (ld_s2),
		.ld_s3     (ld_s3),
		.cfg       (cfg),
		.tick_s1   (tick_s1),
		.scaled_s3 (scaled_s3)
	);

	gsg_update u_update (
		.clk             (clk),
		.arst_n          (arst_n),
		.ld_out          (ld_out),
		.cfg             (cfg),
		.scaled_s3       (scaled_s3),
		.yaw_setpoint    (setpt.yaw_setpoint),
		.pitch_setpoint  (setpt.pitch_setpoint),
		.friction_on     (setpt.friction_on),
		.feeder_one_rate (setpt.feeder_one_rate),
		.feeder_two_rate (setpt.feeder_two_rate)
	);

	// A word waiting in the last stage must not vanish while the result register is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv_out |=> valid_s3)
		else $error("last stage word lost during stall");

	// Feeder one only ever runs backward and feeder two only forward.
	assert property (@(posedge clk) disable iff (!arst_n)
		setpt.valid |-> (setpt.feeder_one_rate[16] || setpt.feeder_one_rate == '0))
		else $error("feeder one rate positive");

	assert property (@(posedge clk) disable iff (!arst_n)
		setpt.valid |-> !setpt.feeder_two_rate[16])
		else $error("feeder two rate negative");

	// The angle state moves only together with a new result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!ld_out |=> $stable(setpt.yaw_setpoint) && $stable(setpt.pitch_setpoint))
		else $error("angle state changed without a result");
endmodule

// ===== dv/tb_gimbal_setpoint_generator.sv =====
`timescale 1ns / 1ps

module tb_gimbal_setpoint_generator;
	import gsg_pkg::*;

	localparam int      FULL_STICK  = 660;
	localparam longint  PITCH_TOP   = (64'd1 << PITCH_W) - 1;
	localparam int      CYCLE_LIMIT = 200000;
	localparam int      REG_WIDTH [8] = '{16, 13, 13, 13, 13, 20, 16, 16};

	// Remote switch positions other than the active one.
	localparam logic [SWITCH_W-1:0] SW_NONE = 2'd0;
	localparam logic [SWITCH_W-1:0] SW_UP   = 2'd1;
	localparam logic [SWITCH_W-1:0] SW_MID  = 2'd3;

	typedef struct packed {
		logic signed [YAW_W-1:0]  yaw_q16;
		logic [PITCH_W-1:0]       pitch_q8;
		logic                     friction_on;
		logic signed [RATE_W-1:0] feeder_one;
		logic signed [RATE_W-1:0] feeder_two;
	} setpoint_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gsg_tick_if  tick_ch ();
	gsg_setpt_if setpt_ch ();

	gimbal_setpoint_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.setpt     (setpt_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gimbal state and register copy as the block should hold them.
	cfg_t              regs_now;
	logic [YAW_W-1:0]  yaw_q16;
	logic [PITCH_W-1:0] pitch_q8;
	logic              sweeping_down;
	logic [19:0]       reg_plan [8];

	tick_t       pending_ticks [$];
	setpoint_t   expected_setpts [$];
	tick_t       tick_word;
	setpoint_t   got_setpt;
	setpoint_t   want_setpt;
	int          tx_gap = 0;
	int          rx_stall = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;

	function automatic setpoint_t advance_gimbal(tick_t t);
		setpoint_t r;
		longint    sy, sp, wh, p, rate, upper_q8, lower_q8, f1, f2;
		logic      fric, fire;
		sy       = longint'($signed(t.stick_yaw));
		sp       = longint'($signed(t.stick_pitch));
		wh       = longint'($signed(t.wheel));
		fric     = (t.friction_switch == SWITCH_ACTIVE);
		fire     = t.fire_request;
		upper_q8 = longint'(regs_now.pitch_upper) * 256;
		lower_q8 = longint'(regs_now.pitch_lower) * 256;
		f1       = 0;
		f2       = 0;
		if (t.mode_switch != SWITCH_ACTIVE) begin
			if (sy != 0)
				yaw_q16 = yaw_q16 - 48'(sy * longint'(regs_now.yaw_stick_gain));
			if (sp != 0) begin
				p = longint'(regs_now.pitch_center) * 256
					+ (sp * longint'(regs_now.pitch_stick_gain) * 256) / FULL_STICK;
				// Upper clamp first, so crossed limits end at the lower one.
				if (p > upper_q8)
					p = upper_q8;
				if (p < lower_q8)
					p = lower_q8;
				if (p < 0)
					p = 0;
				if (p > PITCH_TOP)
					p = PITCH_TOP;
				pitch_q8 = 21'(p);
			end
			rate = (wh * longint'(regs_now.shoot_full_rate)) / FULL_STICK;
			if (rate > longint'(RATE_MAX))
				rate = longint'(RATE_MAX);
			if (rate < -longint'(RATE_MAX))
				rate = -longint'(RATE_MAX);
			if (wh >= longint'(WHEEL_DEADBAND))
				f1 = -rate;
			else if (wh <= -longint'(WHEEL_DEADBAND))
				f2 = -rate;
		end else begin
			if (PATROL_ENABLE && !fire) begin
				yaw_q16 = yaw_q16 + regs_now.yaw_patrol_step;
				if (sweeping_down)
					p = longint'(pitch_q8) - longint'(regs_now.pitch_patrol_step);
				else
					p = longint'(pitch_q8) + longint'(regs_now.pitch_patrol_step);
				if (p < 0)
					p = 0;
				if (p > PITCH_TOP)
					p = PITCH_TOP;
				pitch_q8 = 21'(p);
				if (p > upper_q8)
					sweeping_down = 1'b1;
				if (p < lower_q8)
					sweeping_down = 1'b0;
			end
			if (fric && fire) begin
				f1 = -longint'(regs_now.shoot_full_rate);
				f2 = longint'(regs_now.shoot_full_rate);
			end
		end
		r.yaw_q16     = yaw_q16;
		r.pitch_q8    = pitch_q8;
		r.friction_on = fric;
		r.feeder_one  = 17'(f1);
		r.feeder_two  = 17'(f2);
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		if (mismatch_count < 100)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Tick driver: one word per handshake, with random gaps after a word.
	always @(posedge clk) begin
		if (!arst_n) begin
			tick_ch.valid <= 1'b0;
			tx_gap = 0;
		end else if (!tick_ch.valid || tick_ch.ready) begin
			if (tick_ch.valid) begin
				tick_word.mode_switch     = tick_ch.mode_switch;
				tick_word.friction_switch = tick_ch.friction_switch;
				tick_word.stick_yaw       = tick_ch.stick_yaw;
				tick_word.stick_pitch     = tick_ch.stick_pitch;
				tick_word.wheel           = tick_ch.wheel;
				tick_word.fire_request    = tick_ch.fire_request;
				expected_setpts.push_back(advance_gimbal(tick_word));
			end
			if (tx_gap > 0) begin
				tx_gap--;
				tick_ch.valid <= 1'b0;
			end else if (pending_ticks.size() != 0) begin
				tick_word = pending_ticks.pop_front();
				tick_ch.mode_switch     <= tick_word.mode_switch;
				tick_ch.friction_switch <= tick_word.friction_switch;
				tick_ch.stick_yaw       <= tick_word.stick_yaw;
				tick_ch.stick_pitch     <= tick_word.stick_pitch;
				tick_ch.wheel           <= tick_word.wheel;
				tick_ch.fire_request    <= tick_word.fire_request;
				tick_ch.valid           <= 1'b1;
				if ($urandom_range(0, 99) < tx_idle_pct)
					tx_gap = $urandom_range(1, 14);
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// Setpoint monitor with random receiver stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			setpt_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (setpt_ch.valid && setpt_ch.ready) begin
				got_setpt.yaw_q16     = setpt_ch.yaw_setpoint;
				got_setpt.pitch_q8    = setpt_ch.pitch_setpoint;
				got_setpt.friction_on = setpt_ch.friction_on;
				got_setpt.feeder_one  = setpt_ch.feeder_one_rate;
				got_setpt.feeder_two  = setpt_ch.feeder_two_rate;
				if (expected_setpts.size() == 0) begin
					flag_mismatch("setpoint word with nothing expected");
				end else begin
					want_setpt = expected_setpts.pop_front();
					check_field("yaw_setpoint", got_setpt.yaw_q16, want_setpt.yaw_q16);
					check_field("pitch_setpoint", got_setpt.pitch_q8, want_setpt.pitch_q8);
					check_field("friction_on", got_setpt.friction_on,
						want_setpt.friction_on);
					check_field("feeder_one_rate", got_setpt.feeder_one,
						want_setpt.feeder_one);
					check_field("feeder_two_rate", got_setpt.feeder_two,
						want_setpt.feeder_two);
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				setpt_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				rx_stall = $urandom_range(1, 14) - 1;
				setpt_ch.ready <= 1'b0;
			end else begin
				setpt_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	always @(posedge clk) begin
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_tick(logic [1:0] mode, logic [1:0] fric, int sy, int sp, int wh,
		logic fire);
		tick_t t;
		t.mode_switch     = mode;
		t.friction_switch = fric;
		t.stick_yaw       = 11'(sy);
		t.stick_pitch     = 11'(sp);
		t.wheel           = 11'(wh);
		t.fire_request    = fire;
		pending_ticks.push_back(t);
	endtask

	// Checked on the falling edge, when the driver and monitor updates have settled.
	task automatic drain_ticks();
		while (pending_ticks.size() != 0 || tick_ch.valid || expected_setpts.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_YAW_STICK_GAIN:    regs_now.yaw_stick_gain    = value[15:0];
			REG_PITCH_STICK_GAIN:  regs_now.pitch_stick_gain  = value[12:0];
			REG_PITCH_CENTER:      regs_now.pitch_center      = value[12:0];
			REG_PITCH_UPPER:       regs_now.pitch_upper       = value[12:0];
			REG_PITCH_LOWER:       regs_now.pitch_lower       = value[12:0];
			REG_YAW_PATROL_STEP:   regs_now.yaw_patrol_step   = value[19:0];
			REG_PITCH_PATROL_STEP: regs_now.pitch_patrol_step = value[15:0];
			REG_SHOOT_FULL_RATE:   regs_now.shoot_full_rate   = value[15:0];
			default: ;
		endcase
	endtask

	task automatic program_regs();
		int i;
		for (i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), reg_plan[i]);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [10:0] pick_stick();
		int k;
		case ($urandom_range(0, 9))
			0, 1: k = 0;
			2: k = $urandom_range(0, 1) ? FULL_STICK : -FULL_STICK;
			3: k = int'($urandom_range(45, 55)) * ($urandom_range(0, 1) ? 1 : -1);
			4: k = int'($urandom_range(0, 2047)) - 1024;
			default: k = int'($urandom_range(0, 2 * FULL_STICK)) - FULL_STICK;
		endcase
		return 11'(k);
	endfunction

	function automatic logic [19:0] pick_reg(int width);
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 20'((1 << width) - 1);
			2: return 20'($urandom);
			default: return 20'($urandom_range(0, (1 << width) - 1));
		endcase
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 25;
			default: return 50;
		endcase
	endfunction

	task automatic plan_random_regs();
		int i;
		for (i = 0; i < 8; i++)
			reg_plan[i] = pick_reg(REG_WIDTH[i]);
		// Mostly ordered limits and a step big enough for the sweep to turn around.
		if ($urandom_range(0, 3) != 0) begin
			reg_plan[REG_PITCH_CENTER]      = 20'($urandom_range(2000, 6000));
			reg_plan[REG_PITCH_LOWER]       =
				20'($urandom_range(0, reg_plan[REG_PITCH_CENTER]));
			reg_plan[REG_PITCH_UPPER]       =
				20'($urandom_range(reg_plan[REG_PITCH_CENTER], 8191));
			reg_plan[REG_PITCH_PATROL_STEP] = 20'($urandom_range(256, 30000));
		end
	endtask

	task automatic queue_random_ticks(int count);
		int         left, run_len, fire_pct, i;
		logic [1:0] run_mode, run_fric, mode, fric;
		left = count;
		while (left > 0) begin
			run_len = $urandom_range(1, 40);
			if (run_len > left)
				run_len = left;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: run_mode = SWITCH_ACTIVE;
				4, 5:       run_mode = SW_UP;
				6, 7:       run_mode = SW_MID;
				default:    run_mode = SW_NONE;
			endcase
			run_fric = $urandom_range(0, 2) != 0 ? SWITCH_ACTIVE : SW_UP;
			case ($urandom_range(0, 3))
				0: fire_pct = 0;
				1: fire_pct = 10;
				2: fire_pct = 50;
				default: fire_pct = 100;
			endcase
			for (i = 0; i < run_len; i++) begin
				mode = run_mode;
				fric = run_fric;
				if ($urandom_range(0, 19) == 0)
					mode = 2'($urandom);
				if ($urandom_range(0, 9) == 0)
					fric = 2'($urandom);
				queue_tick(mode, fric, pick_stick(), pick_stick(), pick_stick(),
					$urandom_range(0, 99) < fire_pct);
			end
			left -= run_len;
		end
	endtask

	initial begin
		int phase;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_YAW_STICK_GAIN;
		cfg_data                = '0;
		tick_ch.valid           = 1'b0;
		tick_ch.mode_switch     = SW_UP;
		tick_ch.friction_switch = SW_UP;
		tick_ch.stick_yaw       = '0;
		tick_ch.stick_pitch     = '0;
		tick_ch.wheel           = '0;
		tick_ch.fire_request    = 1'b0;
		setpt_ch.ready          = 1'b0;

		regs_now.yaw_stick_gain    = 16'd26;
		regs_now.pitch_stick_gain  = 13'd568;
		regs_now.pitch_center      = 13'd6000;
		regs_now.pitch_upper       = 13'd7500;
		regs_now.pitch_lower       = 13'd4100;
		regs_now.yaw_patrol_step   = 20'd5243;
		regs_now.pitch_patrol_step = 16'd640;
		regs_now.shoot_full_rate   = 16'd5000;
		yaw_q16       = '0;
		pitch_q8      = '0;
		sweeping_down = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: full deflections, deadband edges, stray switch codes,
		// out-of-range sticks, patrol, and firing with and without the wheels.
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		queue_tick(SW_UP, SW_UP, 0, 0, 0, 1'b0);
		queue_tick(SW_UP, SWITCH_ACTIVE, 660, 660, 660, 1'b0);
		queue_tick(SW_MID, SW_MID, -660, -660, -660, 1'b1);
		queue_tick(SW_UP, SWITCH_ACTIVE, 0, 0, 49, 1'b0);
		queue_tick(SW_UP, SWITCH_ACTIVE, 0, 0, 50, 1'b0);
		queue_tick(SW_UP, SWITCH_ACTIVE, 0, 0, -49, 1'b0);
		queue_tick(SW_UP, SWITCH_ACTIVE, 0, 0, -50, 1'b0);
		queue_tick(SW_NONE, SW_NONE, 1023, 1023, 1023, 1'b0);
		queue_tick(SW_NONE, SW_UP, -1024, -1024, -1024, 1'b1);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SW_UP, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 660, -660, 660, 1'b1);
		queue_tick(SWITCH_ACTIVE, SW_MID, 0, 0, 0, 1'b1);
		drain_ticks();

		// Registers at their top but for the lower limit at zero: pitch clamps high, the wheel
		// rate saturates, and the sweep climbs up from zero.
		reg_plan[REG_YAW_STICK_GAIN]    = 20'hFFFF;
		reg_plan[REG_PITCH_STICK_GAIN]  = 20'd8191;
		reg_plan[REG_PITCH_CENTER]      = 20'd8191;
		reg_plan[REG_PITCH_UPPER]       = 20'd8191;
		reg_plan[REG_PITCH_LOWER]       = 20'd0;
		reg_plan[REG_YAW_PATROL_STEP]   = 20'hFFFFF;
		reg_plan[REG_PITCH_PATROL_STEP] = 20'hFFFF;
		reg_plan[REG_SHOOT_FULL_RATE]   = 20'hFFFF;
		program_regs();
		queue_tick(SW_UP, SWITCH_ACTIVE, 660, 660, 1023, 1'b0);
		queue_tick(SW_MID, SWITCH_ACTIVE, -1024, -660, -1024, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b1);
		drain_ticks();

		// Zero gains and limits: the downward sweep saturates at zero.
		reg_plan[REG_YAW_STICK_GAIN]    = 20'd0;
		reg_plan[REG_PITCH_STICK_GAIN]  = 20'd0;
		reg_plan[REG_PITCH_CENTER]      = 20'd0;
		reg_plan[REG_PITCH_UPPER]       = 20'd0;
		reg_plan[REG_PITCH_LOWER]       = 20'd0;
		reg_plan[REG_YAW_PATROL_STEP]   = 20'd0;
		reg_plan[REG_PITCH_PATROL_STEP] = 20'hFFFF;
		reg_plan[REG_SHOOT_FULL_RATE]   = 20'd0;
		program_regs();
		queue_tick(SW_UP, SWITCH_ACTIVE, 300, 5, 100, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		queue_tick(SWITCH_ACTIVE, SWITCH_ACTIVE, 0, 0, 0, 1'b0);
		drain_ticks();

		// Crossed limits: the lower limit wins.
		reg_plan[REG_PITCH_STICK_GAIN] = 20'd568;
		reg_plan[REG_PITCH_CENTER]     = 20'd4000;
		reg_plan[REG_PITCH_UPPER]      = 20'd1000;
		reg_plan[REG_PITCH_LOWER]      = 20'd7000;
		program_regs();
		queue_tick(SW_UP, SW_UP, 0, 5, 0, 1'b0);
		queue_tick(SW_UP, SW_UP, 0, -660, 0, 1'b0);
		drain_ticks();

		for (phase = 0; phase < 5; phase++) begin
			if (phase == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = pick_idle();
				rx_idle_pct = pick_idle();
			end
			plan_random_regs();
			program_regs();
			queue_random_ticks(110);
			drain_ticks();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
